FILE: src/hjm_pkg.sv
// ----------------------------------------------------------------------------
// hjm_pkg: shared types, constants and helpers for the hand-to-joystick mapper
// Holds the register map, the reset values, the arctangent table and the
// saturation helper that the sequencer and the CORDIC unit use.
// ----------------------------------------------------------------------------
package hjm_pkg;

  // Register map of the configuration port.
  typedef enum logic [2:0] {
    RegActCenter  = 3'd0,
    RegActRadius  = 3'd1,
    RegHoleRadius = 3'd2,
    RegMoveRadius = 3'd3,
    RegDeactBuf   = 3'd4,
    RegTurnThr    = 3'd5,
    RegTurnScale  = 3'd6,
    RegMaxTurn    = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  // Reset values of the registers.
  localparam logic [47:0] ActCenterRst  = 48'd16496927443776;
  localparam logic [14:0] ActRadiusRst  = 15'd1280;
  localparam logic [14:0] HoleRadiusRst = 15'd128;
  localparam logic [14:0] MoveRadiusRst = 15'd640;
  localparam logic [14:0] DeactBufRst   = 15'd640;
  localparam logic [14:0] TurnThrRst    = 15'd2560;
  localparam logic [15:0] TurnScaleRst  = 16'd24576;
  localparam logic [14:0] MaxTurnRst    = 15'd6144;

  // Angles in 1/4096 degree.
  localparam int unsigned AngW = 22;
  localparam logic signed [AngW-1:0] Deg90  = 22'sd368640;
  localparam logic signed [AngW-1:0] Deg180 = 22'sd737280;

  // Divider and square root geometry.
  localparam int unsigned DivNumW  = 48;
  localparam int unsigned DivDenW  = 31;
  localparam int unsigned DivQuoW  = 20;
  localparam int unsigned SqrtInW  = 36;
  localparam int unsigned SqrtOutW = 18;
  localparam int unsigned CordW    = 33;
  localparam int unsigned CordSteps = 16;

  // Control handed from the sequencer to an iterative unit and back.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  // atan(2^-i) in 1/4096 degree, rounded.
  function automatic logic [AngW-1:0] atan_tab(input logic [3:0] idx);
    logic [AngW-1:0] v;
    unique case (idx)
      4'd0:  v = 22'd184320;
      4'd1:  v = 22'd108810;
      4'd2:  v = 22'd57492;
      4'd3:  v = 22'd29184;
      4'd4:  v = 22'd14649;
      4'd5:  v = 22'd7331;
      4'd6:  v = 22'd3667;
      4'd7:  v = 22'd1833;
      4'd8:  v = 22'd917;
      4'd9:  v = 22'd458;
      4'd10: v = 22'd229;
      4'd11: v = 22'd115;
      4'd12: v = 22'd57;
      4'd13: v = 22'd29;
      4'd14: v = 22'd14;
      default: v = 22'd7;
    endcase
    return v;
  endfunction

  // Apply a sign to a magnitude and saturate into 16 signed bits.
  function automatic logic [15:0] sat16(input logic neg, input logic [31:0] mag);
    logic [31:0] m;
    logic [15:0] r;
    m = mag;
    if (neg) begin
      if (m > 32'd32768) m = 32'd32768;
      r = 16'(32'd0 - m);
    end else begin
      if (m > 32'd32767) m = 32'd32767;
      r = m[15:0];
    end
    return r;
  endfunction

endpackage

FILE: src/hjm_if.sv
// ----------------------------------------------------------------------------
// hjm_if: sample and result channels of the hand-to-joystick mapper
// Valid/ready channels; a word moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface hjm_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] palm_x;
  logic signed [15:0] palm_y;
  logic signed [15:0] palm_z;
  logic signed [15:0] finger_x;
  logic signed [15:0] finger_y;
  logic signed [15:0] finger_z;

  modport source (output valid, palm_x, palm_y, palm_z, finger_x, finger_y, finger_z,
                  input ready);
  modport sink   (input valid, palm_x, palm_y, palm_z, finger_x, finger_y, finger_z,
                  output ready);
endinterface

interface hjm_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] forward_speed;
  logic signed [15:0] right_speed;
  logic signed [15:0] turn_rate;
  logic              active;

  modport source (output valid, forward_speed, right_speed, turn_rate, active,
                  input ready);
  modport sink   (input valid, forward_speed, right_speed, turn_rate, active,
                  output ready);
endinterface

FILE: src/hjm_div.sv
// ----------------------------------------------------------------------------
// hjm_div: iterative restoring divider
// One quotient bit per cycle. The dividend's upper part must be below the
// divisor, so the quotient fits its width.
// ----------------------------------------------------------------------------
module hjm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hjm_pkg::unit_req_t               req_i,
  input  logic [hjm_pkg::DivNumW-1:0]      dividend_i,
  input  logic [hjm_pkg::DivDenW-1:0]      divisor_i,
  output hjm_pkg::unit_rsp_t               rsp_o,
  output logic [hjm_pkg::DivQuoW-1:0]      quo_o
);

  localparam int unsigned NumW = hjm_pkg::DivNumW;
  localparam int unsigned DenW = hjm_pkg::DivDenW;
  localparam int unsigned QuoW = hjm_pkg::DivQuoW;

  logic [DenW-1:0] rem_q, rem_d, den_q;
  logic [QuoW-1:0] low_q, low_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic            ge;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_q, low_q[QuoW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = rem_q;
    low_d = low_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = DenW'(dividend_i[NumW-1:QuoW]);
      low_d  = dividend_i[QuoW-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      low_d = {low_q[QuoW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    if (req_i.start) den_q <= divisor_i;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quo_o      = low_q;

endmodule

FILE: src/hjm_sqrt.sv
// ----------------------------------------------------------------------------
// hjm_sqrt: iterative integer square root
// Digit-by-digit method, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module hjm_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hjm_pkg::unit_req_t            req_i,
  input  logic [hjm_pkg::SqrtInW-1:0]   value_i,
  output hjm_pkg::unit_rsp_t            rsp_o,
  output logic [hjm_pkg::SqrtOutW-1:0]  root_o
);

  localparam int unsigned InW  = hjm_pkg::SqrtInW;
  localparam int unsigned OutW = hjm_pkg::SqrtOutW;
  localparam int unsigned RemW = OutW + 2;

  logic [InW-1:0]  rad_q, rad_d;
  logic [OutW-1:0] root_q, root_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [RemW+1:0] cur;
  logic [RemW-1:0] trial;
  logic            ge;

  // One root bit per step.
  always_comb begin
    cur    = {rem_q, rad_q[InW-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = cur >= {2'b00, trial};
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = value_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[InW-3:0], 2'b00};
      rem_d  = ge ? RemW'(cur - {2'b00, trial}) : cur[RemW-1:0];
      root_d = {root_q[OutW-2:0], ge};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'(OutW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign root_o     = root_q;

endmodule

FILE: src/hjm_cordic.sv
// ----------------------------------------------------------------------------
// hjm_cordic: iterative vectoring CORDIC for the tilt angle
// Gives atan2(dy, dz) in 1/4096 degree, one micro-rotation per cycle, after a
// quarter-turn pre-rotation when dz is negative.
// ----------------------------------------------------------------------------
module hjm_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hjm_pkg::unit_req_t                req_i,
  input  logic signed [16:0]                dy_i,
  input  logic signed [16:0]                dz_i,
  output hjm_pkg::unit_rsp_t                rsp_o,
  output logic signed [hjm_pkg::AngW-1:0]   ang_o
);

  localparam int unsigned W = hjm_pkg::CordW;

  logic signed [W-1:0]            x_q, x_d, y_q, y_d, x0, y0, xs, ys;
  logic signed [hjm_pkg::AngW-1:0] z_q, z_d, step_ang;
  logic [3:0]                      i_q, i_d;
  logic                            busy_q, busy_d, done_q, done_d;

  always_comb begin
    x0 = W'(dz_i) <<< 12;
    y0 = W'(dy_i) <<< 12;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    step_ang = signed'(hjm_pkg::atan_tab(i_q));
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      i_d = '0;
      if (dy_i == 17'sd0) begin
        // Vertical or straight-down tilt: the angle is known at once.
        z_d    = dz_i[16] ? hjm_pkg::Deg180 : '0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        if (!dz_i[16]) begin
          x_d = x0;
          y_d = y0;
          z_d = '0;
        end else if (!dy_i[16]) begin
          x_d = y0;
          y_d = -x0;
          z_d = hjm_pkg::Deg90;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -hjm_pkg::Deg90;
        end
      end
    end else if (busy_q) begin
      // Rotate toward the x axis and accumulate the angle.
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + step_ang;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - step_ang;
      end
      i_d = i_q + 4'd1;
      if (i_q == 4'(hjm_pkg::CordSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign ang_o      = z_q;

endmodule

FILE: src/hand_to_joystick_mapper_core.sv
// ----------------------------------------------------------------------------
// hand_to_joystick_mapper_core: palm and finger samples to joystick commands
// Sequencer with a shared multiplier, divider, square root and CORDIC.
// ----------------------------------------------------------------------------
// Each accepted sample word yields one result word. The block takes one
// sample at a time. A sample that leaves the joystick disengaged skips the
// speed and turn work; the disk test runs when the finger is above the
// plane and the joystick is disengaged. An engaged sample runs the 16-step
// CORDIC for the tilt angle, the 20-step divider at most once per speed
// axis outside the dead hole, and past the turn threshold the divider once
// more for the turn fraction and the 18-step square root. Finished results
// sit in an output register, so a new sample is taken while the previous
// result waits. Registers are written through the plain write port and
// should only change while the block is idle.
module hand_to_joystick_mapper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hjm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hjm_pkg::CfgDataW-1:0]  cfg_data_i,
  hjm_in_if.sink                        in_ch,
  hjm_out_if.source                     out_ch
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_DECIDE = 20'h00002,
    S_SQX    = 20'h00004,
    S_SQY    = 20'h00008,
    S_SQR    = 20'h00010,
    S_ACTC   = 20'h00020,
    S_ENG    = 20'h00040,
    S_SPN    = 20'h00080,
    S_SPD    = 20'h00100,
    S_SPDIV  = 20'h00200,
    S_SPWAIT = 20'h00400,
    S_TNCOR  = 20'h00800,
    S_TNCHK  = 20'h01000,
    S_TNDIV  = 20'h02000,
    S_TNSQ   = 20'h04000,
    S_TNSQW  = 20'h08000,
    S_TNM1   = 20'h10000,
    S_TNM2   = 20'h20000,
    S_TNFIN  = 20'h40000,
    S_OUT    = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [47:0] ac_q;
  logic [14:0] ar_q, hr_q, mr_q, db_q, tt_q, mtr_q;
  logic [15:0] ts_q;

  // Sample and engagement state.
  logic signed [15:0] px_q, py_q, pz_q, fx_q, fy_q, fz_q;
  logic signed [15:0] cx_q, cx_d, cy_q, cy_d;
  logic               eng_q, eng_d, axis_q, axis_d;

  // Working registers.
  logic [33:0] acc_q, acc_d;
  logic [31:0] num2_q, num2_d;
  logic [17:0] p_q, p_d;
  logic [39:0] prod_q;
  logic [19:0] mul_a, mul_b;
  logic [15:0] rf_q, rf_d, rr_q, rr_d, rt_q, rt_d;
  logic        ra_q, ra_d;

  // Output register.
  logic        ov_q, ov_d;
  logic [15:0] of_q, or_q, ot_q;
  logic        oa_q;
  logic        load_out;

  // Shared units.
  hjm_pkg::unit_req_t div_req, sq_req, cor_req;
  hjm_pkg::unit_rsp_t div_rsp, sq_rsp, cor_rsp;
  logic [hjm_pkg::DivNumW-1:0]  div_num;
  logic [hjm_pkg::DivDenW-1:0]  div_den;
  logic [hjm_pkg::DivQuoW-1:0]  div_quo;
  logic [hjm_pkg::SqrtOutW-1:0] sq_root;
  logic signed [hjm_pkg::AngW-1:0] cor_ang;

  // Derived values.
  logic signed [15:0] cfg_cx, cfg_cy, cfg_cz;
  logic signed [17:0] low_plane;
  logic signed [16:0] dx, dy, pos, tilt_dy, tilt_dz;
  logic [16:0]        dx_mag, dy_mag, pos_mag, num;
  logic               pos_neg, above, in_hole, degen;
  logic [14:0]        den;
  logic [47:0]        sp_num, tn_num;
  logic               sp_sat;
  logic [20:0]        ang_mag;
  logic [18:0]        thr;
  logic               ang_neg, tilt_dead;
  logic [40:0]        rnd_sum;
  logic [31:0]        tmag;
  logic [15:0]        spd_res;

  // Geometry of the current sample.
  always_comb begin
    cfg_cx    = signed'(ac_q[47:32]);
    cfg_cy    = signed'(ac_q[31:16]);
    cfg_cz    = signed'(ac_q[15:0]);
    above     = fz_q > cfg_cz;
    low_plane = {{2{cfg_cz[15]}}, cfg_cz} - signed'({3'b000, db_q});
    dx        = {fx_q[15], fx_q} - {cfg_cx[15], cfg_cx};
    dy        = {fy_q[15], fy_q} - {cfg_cy[15], cfg_cy};
    dx_mag    = dx[16] ? 17'(-dx) : dx;
    dy_mag    = dy[16] ? 17'(-dy) : dy;
    pos       = axis_q ? ({py_q[15], py_q} - {cy_q[15], cy_q})
                       : ({px_q[15], px_q} - {cx_q[15], cx_q});
    pos_neg   = pos[16];
    pos_mag   = pos_neg ? 17'(-pos) : pos;
    in_hole   = pos_mag <= {2'b00, hr_q};
    degen     = mr_q <= hr_q;
    num       = pos_mag - {2'b00, hr_q};
    den       = mr_q - hr_q;
    // Speed dividend: num^2 * 4096 plus half the squared span for rounding.
    sp_num    = {4'b0, num2_q, 12'b0} + {19'b0, prod_q[29:1]};
    sp_sat    = sp_num[47:17] >= {1'b0, prod_q[29:0]};
    tilt_dy   = {fy_q[15], fy_q} - {py_q[15], py_q};
    tilt_dz   = {fz_q[15], fz_q} - {pz_q[15], pz_q};
    ang_neg   = cor_ang[hjm_pkg::AngW-1];
    ang_mag   = ang_neg ? 21'(-cor_ang) : cor_ang[20:0];
    thr       = {tt_q, 4'b0000};
    tilt_dead = ang_mag < {2'b00, thr};
    tn_num    = {11'b0, 21'(ang_mag - {2'b00, thr}), 16'b0} + 48'd184320;
    rnd_sum   = {1'b0, prod_q} + 41'd32768;
    tmag      = {7'b0, rnd_sum[40:16]};
    spd_res   = hjm_pkg::sat16(pos_neg, {12'b0, div_quo});
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQX: begin
        mul_a = {3'b0, dx_mag};
        mul_b = {3'b0, dx_mag};
      end
      S_SQY: begin
        mul_a = {3'b0, dy_mag};
        mul_b = {3'b0, dy_mag};
      end
      S_SQR: begin
        mul_a = {5'b0, ar_q};
        mul_b = {5'b0, ar_q};
      end
      S_SPN: begin
        mul_a = {3'b0, num};
        mul_b = {3'b0, num};
      end
      S_SPD: begin
        mul_a = {5'b0, den};
        mul_b = {5'b0, den};
      end
      S_TNM1: begin
        mul_a = {2'b0, p_q};
        mul_b = {2'b0, sq_root};
      end
      S_TNM2: begin
        mul_a = rnd_sum[35:16];
        mul_b = {4'b0, ts_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    eng_d   = eng_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    axis_d  = axis_q;
    acc_d   = acc_q;
    num2_d  = num2_q;
    p_d     = p_q;
    rf_d    = rf_q;
    rr_d    = rr_q;
    rt_d    = rt_q;
    ra_d    = ra_q;
    div_req.start = 1'b0;
    sq_req.start  = 1'b0;
    cor_req.start = 1'b0;
    div_num = tn_num;
    div_den = 31'd368640;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (above && !eng_q) begin
          state_d = S_SQX;
        end else begin
          if (!above && eng_q && (signed'({{2{fz_q[15]}}, fz_q}) < low_plane)) begin
            eng_d = 1'b0;
          end
          state_d = S_ENG;
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        acc_d   = {2'b00, prod_q[31:0]};
        state_d = S_SQR;
      end
      S_SQR: begin
        acc_d   = acc_q + {2'b00, prod_q[31:0]};
        state_d = S_ACTC;
      end
      S_ACTC: begin
        // Engage inside the activation disk and latch the palm as center.
        if ({6'b0, acc_q} < prod_q) begin
          eng_d = 1'b1;
          cx_d  = px_q;
          cy_d  = py_q;
        end
        state_d = S_ENG;
      end
      S_ENG: begin
        rf_d = '0;
        rr_d = '0;
        rt_d = '0;
        ra_d = eng_q;
        axis_d  = 1'b0;
        state_d = eng_q ? S_SPN : S_OUT;
      end
      S_SPN: begin
        if (in_hole || degen) begin
          if (!in_hole) begin
            if (axis_q) rr_d = hjm_pkg::sat16(pos_neg, 32'd32768);
            else        rf_d = hjm_pkg::sat16(pos_neg, 32'd32768);
          end
          axis_d  = 1'b1;
          state_d = axis_q ? S_TNCOR : S_SPN;
        end else begin
          state_d = S_SPD;
        end
      end
      S_SPD: begin
        num2_d  = prod_q[31:0];
        state_d = S_SPDIV;
      end
      S_SPDIV: begin
        div_num = sp_num;
        div_den = {1'b0, prod_q[29:0]};
        if (sp_sat) begin
          if (axis_q) rr_d = hjm_pkg::sat16(pos_neg, 32'd32768);
          else        rf_d = hjm_pkg::sat16(pos_neg, 32'd32768);
          axis_d  = 1'b1;
          state_d = axis_q ? S_TNCOR : S_SPN;
        end else begin
          div_req.start = 1'b1;
          state_d = S_SPWAIT;
        end
      end
      S_SPWAIT: begin
        if (div_rsp.done) begin
          if (axis_q) rr_d = spd_res;
          else        rf_d = spd_res;
          axis_d  = 1'b1;
          state_d = axis_q ? S_TNCOR : S_SPN;
        end
      end
      S_TNCOR: begin
        cor_req.start = 1'b1;
        state_d = S_TNCHK;
      end
      S_TNCHK: begin
        if (cor_rsp.done) begin
          if (tilt_dead) begin
            state_d = S_OUT;
          end else begin
            div_req.start = 1'b1;
            state_d = S_TNDIV;
          end
        end
      end
      S_TNDIV: begin
        if (div_rsp.done) begin
          p_d     = div_quo[17:0];
          state_d = S_TNSQ;
        end
      end
      S_TNSQ: begin
        sq_req.start = 1'b1;
        state_d = S_TNSQW;
      end
      S_TNSQW: begin
        if (sq_rsp.done) state_d = S_TNM1;
      end
      S_TNM1: state_d = S_TNM2;
      S_TNM2: state_d = S_TNFIN;
      S_TNFIN: begin
        // Positive rates clamp at the register; negative ones saturate.
        if (ang_neg) begin
          rt_d = hjm_pkg::sat16(1'b1, tmag);
        end else if (tmag > {17'b0, mtr_q}) begin
          rt_d = hjm_pkg::sat16(1'b0, {17'b0, mtr_q});
        end else begin
          rt_d = hjm_pkg::sat16(1'b0, tmag);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_ch.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q && !out_ch.ready;
    if (load_out) ov_d = 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      eng_q   <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      ov_q    <= 1'b0;
      axis_q  <= 1'b0;
      ac_q    <= hjm_pkg::ActCenterRst;
      ar_q    <= hjm_pkg::ActRadiusRst;
      hr_q    <= hjm_pkg::HoleRadiusRst;
      mr_q    <= hjm_pkg::MoveRadiusRst;
      db_q    <= hjm_pkg::DeactBufRst;
      tt_q    <= hjm_pkg::TurnThrRst;
      ts_q    <= hjm_pkg::TurnScaleRst;
      mtr_q   <= hjm_pkg::MaxTurnRst;
    end else begin
      state_q <= state_d;
      eng_q   <= eng_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      ov_q    <= ov_d;
      axis_q  <= axis_d;
      if (cfg_we_i) begin
        unique case (hjm_pkg::cfg_reg_e'(cfg_idx_i))
          hjm_pkg::RegActCenter:  ac_q  <= cfg_data_i;
          hjm_pkg::RegActRadius:  ar_q  <= cfg_data_i[14:0];
          hjm_pkg::RegHoleRadius: hr_q  <= cfg_data_i[14:0];
          hjm_pkg::RegMoveRadius: mr_q  <= cfg_data_i[14:0];
          hjm_pkg::RegDeactBuf:   db_q  <= cfg_data_i[14:0];
          hjm_pkg::RegTurnThr:    tt_q  <= cfg_data_i[14:0];
          hjm_pkg::RegTurnScale:  ts_q  <= cfg_data_i[15:0];
          hjm_pkg::RegMaxTurn:    mtr_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_ch.valid) begin
      px_q <= in_ch.palm_x;
      py_q <= in_ch.palm_y;
      pz_q <= in_ch.palm_z;
      fx_q <= in_ch.finger_x;
      fy_q <= in_ch.finger_y;
      fz_q <= in_ch.finger_z;
    end
    acc_q  <= acc_d;
    num2_q <= num2_d;
    p_q    <= p_d;
    rf_q   <= rf_d;
    rr_q   <= rr_d;
    rt_q   <= rt_d;
    ra_q   <= ra_d;
    if (load_out) begin
      of_q <= rf_q;
      or_q <= rr_q;
      ot_q <= rt_q;
      oa_q <= ra_q;
    end
  end

  hjm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .rsp_o      (div_rsp),
    .quo_o      (div_quo)
  );

  hjm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sq_req),
    .value_i ({2'b00, p_q, 16'b0}),
    .rsp_o   (sq_rsp),
    .root_o  (sq_root)
  );

  hjm_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .dy_i   (tilt_dy),
    .dz_i   (tilt_dz),
    .rsp_o  (cor_rsp),
    .ang_o  (cor_ang)
  );

  // Ports.
  assign in_ch.ready          = (state_q == S_IDLE);
  assign out_ch.valid         = ov_q;
  assign out_ch.forward_speed = signed'(of_q);
  assign out_ch.right_speed   = signed'(or_q);
  assign out_ch.turn_rate     = signed'(ot_q);
  assign out_ch.active        = oa_q;

  // A disengaged result carries no motion.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.active) |->
      (of_q == 16'd0 && or_q == 16'd0 && ot_q == 16'd0))
    else $error("disengaged result with nonzero motion");

  // A positive turn rate never passes the clamp.
  a_turn_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TNFIN && !ang_neg) |=> (rt_q <= {1'b0, mtr_q}))
    else $error("turn rate above clamp");

  // One sample at a time: after an accept the block is busy.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second sample taken while busy");

  // The divider only reports completion to a state waiting for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_SPWAIT || state_q == S_TNDIV))
    else $error("divider result with no consumer");

endmodule

FILE: sim/hand_to_joystick_mapper_core_test.sv
// ----------------------------------------------------------------------------
// hand_to_joystick_mapper_core_test: self-checking bench for the joystick mapper
// Drives palm and finger sample words with random idling on both channels,
// predicts each result word from an internal model of engagement, speeds
// and tilt-based turn rate, and checks every result field in order.
// ----------------------------------------------------------------------------
module hand_to_joystick_mapper_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] px, py, pz, fx, fy, fz;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] fwd, rgt, trn;
    logic               act;
  } command_t;

  localparam longint QuarterTurn = 368640;
  localparam longint HalfTurn    = 737280;

  // Scoreboard: holds the mapper model and the queue of expected commands.
  class joystick_scoreboard;
    logic [47:0] act_center;
    logic [14:0] act_radius, hole_radius, move_radius, deact_buf, turn_thr, max_turn;
    logic [15:0] turn_scale;
    bit          engaged;
    int          ctr_x, ctr_y;
    command_t    pending[$];
    int          errors;

    function new();
      act_center  = hjm_pkg::ActCenterRst;
      act_radius  = hjm_pkg::ActRadiusRst;
      hole_radius = hjm_pkg::HoleRadiusRst;
      move_radius = hjm_pkg::MoveRadiusRst;
      deact_buf   = hjm_pkg::DeactBufRst;
      turn_thr    = hjm_pkg::TurnThrRst;
      turn_scale  = hjm_pkg::TurnScaleRst;
      max_turn    = hjm_pkg::MaxTurnRst;
      engaged     = 0;
      ctr_x       = 0;
      ctr_y       = 0;
      errors      = 0;
    endfunction

    function void set_reg(hjm_pkg::cfg_reg_e idx, logic [47:0] val);
      case (idx)
        hjm_pkg::RegActCenter:  act_center  = val;
        hjm_pkg::RegActRadius:  act_radius  = val[14:0];
        hjm_pkg::RegHoleRadius: hole_radius = val[14:0];
        hjm_pkg::RegMoveRadius: move_radius = val[14:0];
        hjm_pkg::RegDeactBuf:   deact_buf   = val[14:0];
        hjm_pkg::RegTurnThr:    turn_thr    = val[14:0];
        hjm_pkg::RegTurnScale:  turn_scale  = val[15:0];
        default:                max_turn    = val[14:0];
      endcase
    endfunction

    function logic [15:0] clip16(bit neg, longint mag);
      if (neg) begin
        if (mag > 32768) mag = 32768;
        return 16'(-mag);
      end
      if (mag > 32767) mag = 32767;
      return 16'(mag);
    endfunction

    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - r - b;
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function logic [15:0] axis_speed(int off);
      longint a, num, den, mag;
      a = off < 0 ? -off : off;
      if (a <= hole_radius) return 16'd0;
      num = a - hole_radius;
      if (move_radius <= hole_radius) begin
        mag = 32768;
      end else begin
        den = move_radius - hole_radius;
        den = den * den;
        mag = (num * num * 4096 + den / 2) / den;
      end
      return clip16(off < 0, mag);
    endfunction

    // CORDIC vectoring in 1/4096 degree with a quarter-turn pre-rotation.
    function longint tilt(int dy, int dz);
      longint x, y, z, nx, ny;
      longint atans[16];
      atans = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                917, 458, 229, 115, 57, 29, 14, 7};
      if (dy == 0) return dz < 0 ? HalfTurn : 0;
      x = longint'(dz) * 4096;
      y = longint'(dy) * 4096;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          nx = y; ny = -x; z = QuarterTurn;
        end else begin
          nx = -y; ny = x; z = -QuarterTurn;
        end
        x = nx;
        y = ny;
      end
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atans[i];
        end else begin
          nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atans[i];
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    function logic [15:0] turn_rate(int dy, int dz);
      longint ang, a, thr, p, s, pw, mag;
      ang = tilt(dy, dz);
      a   = ang < 0 ? -ang : ang;
      thr = longint'(turn_thr) * 16;
      if (a < thr) return 16'd0;
      p   = ((a - thr) * 65536 + QuarterTurn / 2) / QuarterTurn;
      s   = int_sqrt(p << 16);
      pw  = (p * s + 32768) >> 16;
      mag = (pw * turn_scale + 32768) >> 16;
      if (ang < 0) return clip16(1, mag);
      if (mag > max_turn) mag = max_turn;
      return clip16(0, mag);
    endfunction

    // Note an accepted sample word and queue the command it should produce.
    function void note_sample(sample_t s);
      int cx, cy, cz;
      longint dx, dy;
      command_t c;
      cx = $signed(act_center[47:32]);
      cy = $signed(act_center[31:16]);
      cz = $signed(act_center[15:0]);
      if (s.fz > cz) begin
        if (!engaged) begin
          dx = longint'(s.fx) - cx;
          dy = longint'(s.fy) - cy;
          if (dx * dx + dy * dy < longint'(act_radius) * act_radius) begin
            engaged = 1;
            ctr_x = s.px;
            ctr_y = s.py;
          end
        end
      end else if (engaged && s.fz < cz - int'(deact_buf)) begin
        engaged = 0;
      end
      c = '0;
      if (engaged) begin
        c.fwd = axis_speed(int'(s.px) - ctr_x);
        c.rgt = axis_speed(int'(s.py) - ctr_y);
        c.trn = turn_rate(int'(s.fy) - s.py, int'(s.fz) - s.pz);
        c.act = 1;
      end
      pending.push_back(c);
    endfunction

    // Check a result word against the oldest expectation.
    function void check_command(command_t got);
      command_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word fwd=%0d rgt=%0d trn=%0d act=%0d", $time,
                 got.fwd, got.rgt, got.trn, got.act);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        $display("%0t: mismatch expected fwd=%0d rgt=%0d trn=%0d act=%0d", $time,
                 exp_c.fwd, exp_c.rgt, exp_c.trn, exp_c.act);
        $display("%0t:          actual   fwd=%0d rgt=%0d trn=%0d act=%0d", $time,
                 got.fwd, got.rgt, got.trn, got.act);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [hjm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [hjm_pkg::CfgDataW-1:0] cfg_data_i;

  hjm_in_if  in_ch ();
  hjm_out_if out_ch ();

  hand_to_joystick_mapper_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  joystick_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls plus long hold-offs on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_command({out_ch.forward_speed, out_ch.right_speed, out_ch.turn_rate,
                        out_ch.active});
    end
  end

  // Sample monitor.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_sample({in_ch.palm_x, in_ch.palm_y, in_ch.palm_z, in_ch.finger_x,
                      in_ch.finger_y, in_ch.finger_z});
    end
  end

  task automatic write_reg(hjm_pkg::cfg_reg_e idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop the sample channel, then wait until every result word is back and
  // the block has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // Offer one sample word, with random idle cycles before it.
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.palm_x   <= s.px;
    in_ch.palm_y   <= s.py;
    in_ch.palm_z   <= s.pz;
    in_ch.finger_x <= s.fx;
    in_ch.finger_y <= s.fy;
    in_ch.finger_z <= s.fz;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] near(int base, int span);
    int v;
    v = base + $signed($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [47:0] center_word(int x, int y, int z);
    return {16'(x), 16'(y), 16'(z)};
  endfunction

  // One gesture: engage inside the disk, move around, then drop out.
  task automatic send_gesture(int n);
    int cx, cy, cz;
    sample_t s;
    cx = $signed(sb.act_center[47:32]);
    cy = $signed(sb.act_center[31:16]);
    cz = $signed(sb.act_center[15:0]);
    for (int i = 0; i < n; i++) begin
      s.px = near(cx, 1500);
      s.py = near(cy, 1500);
      s.pz = near(cz, 800);
      s.fx = near(cx, (i == 0) ? int'(sb.act_radius) / 2 : 2000);
      s.fy = near(cy, (i == 0) ? int'(sb.act_radius) / 2 : 2000);
      s.fz = (i == n - 1) ? near(cz - int'(sb.deact_buf) - 200, 150) :
             near(cz + 300, ($urandom_range(3) == 0) ? 1200 : 250);
      send_sample(s);
    end
  endtask

  task automatic send_noise();
    send_sample({16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom)});
  endtask

  // Directed samples over the default settings; the disk center is at
  // 3840,-640 and the plane at 2880.
  task automatic send_directed();
    send_sample('0);
    send_sample({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_sample({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    // Engage with the palm at 1000,-640 and the finger straight up.
    send_sample({16'sd1000, -16'sd640, 16'sd2880, 16'sd3840, -16'sd640, 16'sd3180});
    // Inside the dead hole and dead tilt.
    send_sample({16'sd1050, -16'sd590, 16'sd2880, 16'sd3840, -16'sd590, 16'sd3180});
    // Positive and negative tilts, far offsets for saturation.
    send_sample({16'sd2000, -16'sd2640, 16'sd2880, 16'sd0, -16'sd2240, 16'sd3180});
    send_sample({-16'sd30000, 16'sd30000, 16'sd2880, 16'sd0, -16'sd32000, 16'sd3180});
    // Zero Y difference with the finger under the palm: half a turn.
    send_sample({16'sd1000, 16'sd0, 16'sd3300, 16'sd0, 16'sd0, 16'sd3100});
    // Finger below palm with both tilt signs.
    send_sample({16'sd1000, 16'sd0, 16'sd3500, 16'sd0, 16'sd200, 16'sd3100});
    send_sample({16'sd1000, 16'sd0, 16'sd3500, 16'sd0, -16'sd200, 16'sd3100});
    // Hovering inside the buffer stays engaged, below it disengages.
    send_sample({16'sd1000, 16'sd0, 16'sd2880, 16'sd0, 16'sd0, 16'sd2240});
    send_sample({16'sd1000, 16'sd0, 16'sd2880, 16'sd0, 16'sd0, 16'sd2239});
    // Finger above the plane but exactly on the disk edge.
    send_sample({16'sd0, 16'sd0, 16'sd2880, 16'sd5120, -16'sd640, 16'sd3180});
  endtask

  // Main sequence.
  initial begin
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.palm_x   = '0;
    in_ch.palm_y   = '0;
    in_ch.palm_z   = '0;
    in_ch.finger_x = '0;
    in_ch.finger_y = '0;
    in_ch.finger_z = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_off       = 0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 16 : (ph % 3 == 1) ? 64 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 64 : (ph % 3 == 1) ? 16 : 0;
      case (ph)
        1: begin
          // Extremes: tiny disk at the top corner, degenerate radii, full gain.
          write_reg(hjm_pkg::RegActCenter, center_word(32767, 32767, 32767));
          write_reg(hjm_pkg::RegActRadius, 48'd0);
          write_reg(hjm_pkg::RegHoleRadius, 48'd32767);
          write_reg(hjm_pkg::RegMoveRadius, 48'd1);
          write_reg(hjm_pkg::RegDeactBuf, 48'd0);
          write_reg(hjm_pkg::RegTurnThr, 48'd0);
          write_reg(hjm_pkg::RegTurnScale, 48'd65535);
          write_reg(hjm_pkg::RegMaxTurn, 48'd32767);
        end
        2: begin
          write_reg(hjm_pkg::RegActCenter, center_word(-32768, -32768, -32768));
          write_reg(hjm_pkg::RegActRadius, 48'd32767);
          write_reg(hjm_pkg::RegHoleRadius, 48'd0);
          write_reg(hjm_pkg::RegMoveRadius, 48'd32767);
          write_reg(hjm_pkg::RegDeactBuf, 48'd32767);
          write_reg(hjm_pkg::RegTurnThr, 48'd23040);
          write_reg(hjm_pkg::RegTurnScale, 48'd0);
          write_reg(hjm_pkg::RegMaxTurn, 48'd0);
        end
        3, 4, 5: begin
          write_reg(hjm_pkg::RegActCenter,
                    center_word($signed($urandom_range(4000)) - 2000,
                                $signed($urandom_range(4000)) - 2000,
                                $signed($urandom_range(4000)) - 2000));
          write_reg(hjm_pkg::RegActRadius, 48'($urandom_range(3000, 200)));
          write_reg(hjm_pkg::RegHoleRadius, 48'($urandom_range(400)));
          write_reg(hjm_pkg::RegMoveRadius, 48'($urandom_range(2000, 1)));
          write_reg(hjm_pkg::RegDeactBuf, 48'($urandom_range(1000)));
          write_reg(hjm_pkg::RegTurnThr, 48'($urandom_range(23040)));
          write_reg(hjm_pkg::RegTurnScale, 48'($urandom));
          write_reg(hjm_pkg::RegMaxTurn, 48'($urandom_range(32767)));
        end
        default: ;
      endcase
      for (int n = 0; n < 270; ) begin
        // Steps are at most 8 items, so this window is always hit.
        if (ph == 0 && n >= 100 && n < 108) hold_off = 400;
        if ($urandom_range(9) < 8) begin
          send_gesture(8);
          n += 8;
        end else begin
          send_noise();
          n++;
        end
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
